// ===== src/midi_drum_note_measure_timestamper_assert.svh =====
// Assertion macros shared by the checker of the drum note timestamper.
// Each macro samples on the rising edge of clk; the reset is rst.
`ifndef MIDI_DRUM_NOTE_MEASURE_TIMESTAMPER_ASSERT_SVH
`define MIDI_DRUM_NOTE_MEASURE_TIMESTAMPER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define MDNT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdnt: property failed");

// Consequent must hold in the cycle after reset is applied.
`define MDNT_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("mdnt: reset property failed");

`endif

// ===== src/mdnt_pkg.sv =====
// Package for the drum note timestamper: item kinds, parser phases,
// controller states and fixed constants. No dependencies.
`default_nettype none
package mdnt_pkg;

  localparam int KIND_BITS    = 2;
  localparam int TIME_IN_BITS = 32;
  localparam int BYTE_BITS    = 8;
  localparam int BEAT_BITS    = 8;
  localparam int BPM_BITS     = 16;
  localparam int PITCH_BITS   = 7;
  localparam int POS_OUT_BITS = 16;

  localparam logic [KIND_BITS-1:0] KIND_MIDI  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_BEAT  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_START = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_STOP  = 2'd3;

  localparam logic [BYTE_BITS-1:0] NOTE_ON_CH10  = 8'h99;
  localparam logic [BEAT_BITS-1:0] DEFAULT_BEATS = 8'd4;

  // Microseconds per minute fits in 26 bits.
  localparam int                  DIV_BITS      = 26;
  localparam logic [DIV_BITS-1:0] US_PER_MINUTE = 26'd60000000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NOTE_ON,
    PH_PITCH
  } phase_t;

  typedef enum logic {
    F_READY,
    F_DIV
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/mdnt_queue.sv =====
// Short request queue between front and back of the timestamper.
// Depends on nothing but its parameters.
`default_nettype none
module mdnt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mdnt_front.sv =====
// Front of the timestamper: MIDI parser, beat and tempo tracking, and the
// serial divider for the tempo. Emits note requests. Uses mdnt_pkg.
`default_nettype none
module mdnt_front #(
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [mdnt_pkg::KIND_BITS-1:0]      kind,
  input  logic [mdnt_pkg::TIME_IN_BITS-1:0]   time_us,
  input  logic [mdnt_pkg::BYTE_BITS-1:0]      midi_byte,
  input  logic [mdnt_pkg::BEAT_BITS-1:0]      sub_division,
  input  logic [mdnt_pkg::BPM_BITS-1:0]       tempo_bpm,
  input  logic [mdnt_pkg::BEAT_BITS-1:0]      measure_beats,
  output logic                                busy,
  output logic                                job_push,
  output logic [mdnt_pkg::PITCH_BITS + 2*TIME_BITS + 2*mdnt_pkg::BEAT_BITS - 1:0] job_data
);
  import mdnt_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS);

  front_state_t         state;
  front_state_t         state_next;
  phase_t               phase;
  logic                 is_running;
  logic [TIME_BITS-1:0] last_beat_time;
  logic [TIME_BITS-1:0] beat_length;
  logic [BEAT_BITS-1:0] beat_index;
  logic [BEAT_BITS-1:0] beats_in_measure;

  logic [TIME_BITS-1:0] start_time;
  logic [BPM_BITS-1:0]  div_bpm;
  logic [BPM_BITS-1:0]  div_rem;
  logic [DIV_BITS-1:0]  div_quo;
  logic [CNT_W-1:0]     div_cnt;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] elapsed;
  logic [BEAT_BITS-1:0] beat_next;
  logic [BEAT_BITS-1:0] beats_eff;
  logic [BPM_BITS:0]    rem_shift;
  logic [BPM_BITS:0]    rem_sub;
  logic                 rem_ge;
  logic [DIV_BITS-1:0]  quo_final;
  logic [TIME_BITS-1:0] quo_time;

  assign now       = TIME_BITS'(time_us);
  assign elapsed   = now - last_beat_time;
  assign beat_next = beat_index + 1'b1;
  assign beats_eff = (measure_beats == '0) ? DEFAULT_BEATS : measure_beats;

  // One restoring step per cycle, dividend bits taken from the constant.
  assign rem_shift = {div_rem, US_PER_MINUTE[div_cnt]};
  assign rem_ge    = (rem_shift >= {1'b0, div_bpm});
  assign rem_sub   = rem_shift - {1'b0, div_bpm};
  assign quo_final = {div_quo[DIV_BITS-2:0], rem_ge};
  assign quo_time  = TIME_BITS'(quo_final);

  assign job_push = accept && (kind == KIND_MIDI) && !midi_byte[BYTE_BITS-1]
                    && (phase == PH_NOTE_ON) && is_running;
  assign job_data = {midi_byte[PITCH_BITS-1:0], elapsed, beat_length,
                     beat_index, beats_in_measure};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_READY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      F_READY: begin
        if (accept && (kind == KIND_START) && (tempo_bpm != '0)) begin
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        busy = 1'b1;
        if (div_cnt == '0) begin
          state_next = F_READY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      is_running       <= 1'b0;
      last_beat_time   <= '0;
      beat_length      <= '0;
      beat_index       <= '0;
      beats_in_measure <= DEFAULT_BEATS;
    end else begin
      if (state == F_DIV) begin
        div_rem <= rem_ge ? rem_sub[BPM_BITS-1:0] : rem_shift[BPM_BITS-1:0];
        div_quo <= quo_final;
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == '0) begin
          beat_length    <= quo_time;
          last_beat_time <= start_time - quo_time;
        end
      end
      if (accept) begin
        unique case (kind)
          KIND_MIDI: begin
            if (midi_byte[BYTE_BITS-1]) begin
              phase <= (midi_byte == NOTE_ON_CH10) ? PH_NOTE_ON : PH_IDLE;
            end else begin
              unique case (phase)
                PH_NOTE_ON: phase <= PH_PITCH;
                PH_PITCH:   phase <= PH_IDLE;
                default:    phase <= phase;
              endcase
            end
          end
          KIND_BEAT: begin
            if (sub_division == '0) begin
              beat_length    <= elapsed;
              last_beat_time <= now;
              beat_index     <= (beat_next == beats_in_measure) ? '0 : beat_next;
            end
          end
          KIND_START: begin
            beats_in_measure <= beats_eff;
            beat_index       <= beats_eff - 1'b1;
            is_running       <= 1'b1;
            start_time       <= now;
            div_bpm          <= tempo_bpm;
            div_rem          <= '0;
            div_quo          <= '0;
            div_cnt          <= CNT_W'(DIV_BITS - 1);
            if (tempo_bpm == '0) begin
              beat_length    <= '0;
              last_beat_time <= now;
            end
          end
          KIND_STOP: begin
            is_running <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mdnt_back.sv =====
// Back of the timestamper: turns a note request into its measure position
// with a bit-serial long division, and holds the result. Uses mdnt_pkg.
`default_nettype none
module mdnt_back #(
  parameter int TIME_BITS     = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  input  logic [mdnt_pkg::PITCH_BITS + 2*TIME_BITS + 2*mdnt_pkg::BEAT_BITS - 1:0] job_data,
  output logic                                job_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic [mdnt_pkg::PITCH_BITS-1:0]     note_pitch,
  output logic [mdnt_pkg::POS_OUT_BITS-1:0]   note_position
);
  import mdnt_pkg::*;

  localparam int DEN_W     = TIME_BITS + BEAT_BITS;
  localparam int SUM_W     = DEN_W + 1;
  localparam int DIV_STEPS = SUM_W + POSITION_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  back_state_t             state;
  back_state_t             state_next;
  logic [PITCH_BITS-1:0]   pitch;
  logic [TIME_BITS-1:0]    elapsed;
  logic [TIME_BITS-1:0]    blen;
  logic [BEAT_BITS-1:0]    bidx;
  logic [BEAT_BITS-1:0]    bmeas;
  logic [DEN_W-1:0]        prod_idx;
  logic [DEN_W-1:0]        den;
  logic [DIV_STEPS-1:0]    dividend;
  logic [DEN_W-1:0]        rem;
  logic [POSITION_BITS-1:0] quo;
  logic [STEP_W-1:0]       step;
  logic                    out_valid;
  logic                    load_out;

  logic [SUM_W-1:0]        sum_calc;
  logic [DEN_W:0]          rem_shift;
  logic [DEN_W:0]          rem_sub;
  logic                    rem_ge;

  assign sum_calc  = SUM_W'(elapsed) + SUM_W'(prod_idx);
  assign rem_shift = {rem, dividend[DIV_STEPS-1]};
  assign rem_ge    = (rem_shift >= {1'b0, den});
  assign rem_sub   = rem_shift - {1'b0, den};

  assign job_pop = (state == B_IDLE) && job_valid;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          state_next = B_MUL;
        end
      end
      B_MUL: state_next = B_SUM;
      B_SUM: state_next = (den == '0) ? B_DONE : B_DIV;
      B_DIV: begin
        if (step == '0) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        // hold until the result register is free
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        {pitch, elapsed, blen, bidx, bmeas} <= job_data;
      end
      B_MUL: begin
        prod_idx <= DEN_W'(blen) * DEN_W'(bidx);
        den      <= DEN_W'(blen) * DEN_W'(bmeas);
      end
      B_SUM: begin
        dividend <= {sum_calc, {POSITION_BITS{1'b0}}};
        rem      <= '0;
        quo      <= '0;
        step     <= STEP_W'(DIV_STEPS - 1);
      end
      B_DIV: begin
        rem      <= rem_ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        quo      <= {quo[POSITION_BITS-2:0], rem_ge};
        dividend <= dividend << 1;
        step     <= step - 1'b1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      note_pitch    <= pitch;
      note_position <= POS_OUT_BITS'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/midi_drum_note_measure_timestamper.sv =====
// Drum note timestamper: note-on parser with position in the measure.
// Path: a pitch byte writes a note request into the queue; the back pops it and runs
// multiply, sum, bit-serial division and the result register, one note at a time.
// Throughput: one item per cycle, except a start with nonzero tempo, which holds the
// input while the tempo divider runs, and any item while the two-entry queue is full.
// Reset: synchronous rst clears parser, tempo state, queue and the result valid flag.
`default_nettype none
module midi_drum_note_measure_timestamper #(
  parameter int TIME_BITS     = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [mdnt_pkg::KIND_BITS-1:0]      kind,
  input  logic [mdnt_pkg::TIME_IN_BITS-1:0]   time_us,
  input  logic [mdnt_pkg::BYTE_BITS-1:0]      midi_byte,
  input  logic [mdnt_pkg::BEAT_BITS-1:0]      sub_division,
  input  logic [mdnt_pkg::BPM_BITS-1:0]       tempo_bpm,
  input  logic [mdnt_pkg::BEAT_BITS-1:0]      measure_beats,
  output logic                                empty,
  input  logic                                pop,
  output logic [mdnt_pkg::PITCH_BITS-1:0]     note_pitch,
  output logic [mdnt_pkg::POS_OUT_BITS-1:0]   note_position
);
  import mdnt_pkg::*;

  localparam int JOB_W       = PITCH_BITS + 2*TIME_BITS + 2*BEAT_BITS;
  localparam int QUEUE_DEPTH = 2;

  logic             accept;
  logic             front_busy;
  logic             job_push;
  logic [JOB_W-1:0] job_wr;
  logic [JOB_W-1:0] job_rd;
  logic             queue_full;
  logic             job_valid;
  logic             job_pop;

  assign full   = front_busy || queue_full;
  assign accept = push && !full;

  mdnt_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .kind          (kind),
    .time_us       (time_us),
    .midi_byte     (midi_byte),
    .sub_division  (sub_division),
    .tempo_bpm     (tempo_bpm),
    .measure_beats (measure_beats),
    .busy          (front_busy),
    .job_push      (job_push),
    .job_data      (job_wr)
  );

  mdnt_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_wr),
    .full    (queue_full),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .valid   (job_valid)
  );

  mdnt_back #(
    .TIME_BITS     (TIME_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_data      (job_rd),
    .job_pop       (job_pop),
    .empty         (empty),
    .pop           (pop),
    .note_pitch    (note_pitch),
    .note_position (note_position)
  );

endmodule
`default_nettype wire

// ===== src/mdnt_checker.sv =====
// Port-level checks for the drum note timestamper, bound to the top level.
// Uses mdnt_pkg and the assertion macro header.
`default_nettype none
`include "midi_drum_note_measure_timestamper_assert.svh"
module mdnt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                push,
  input logic                                full,
  input logic [mdnt_pkg::KIND_BITS-1:0]      kind,
  input logic [mdnt_pkg::BPM_BITS-1:0]       tempo_bpm,
  input logic                                empty,
  input logic                                pop,
  input logic [mdnt_pkg::PITCH_BITS-1:0]     note_pitch,
  input logic [mdnt_pkg::POS_OUT_BITS-1:0]   note_position
);
  import mdnt_pkg::*;

  // reset leaves no result and an open input
  `MDNT_ASSERT_AFTER_RESET(a_reset_clear, empty && !full)

  // a waiting result holds until taken
  `MDNT_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(note_pitch) && $stable(note_position))

  // a start with a tempo occupies the tempo divider
  `MDNT_ASSERT_NEXT(a_start_busy, push && !full && (kind == KIND_START) && (tempo_bpm != '0), full)

  // beats and stops never close the input
  `MDNT_ASSERT_NEXT(a_open_after, push && !full && ((kind == KIND_BEAT) || (kind == KIND_STOP)), !full)

endmodule

bind midi_drum_note_measure_timestamper mdnt_checker u_mdnt_checker (.*);
`default_nettype wire

// ===== tb/sv/midi_drum_note_measure_timestamper_tb.sv =====
// Self-checking bench for the drum note timestamper: a queue-fed driver, a
// result monitor and an in-bench predictor of pitch and measure position.
// Depends on mdnt_pkg and midi_drum_note_measure_timestamper only.
`timescale 1ns / 1ps
module midi_drum_note_measure_timestamper_tb;
  import mdnt_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_CYCLES = 1_000_000;

  typedef struct {
    logic [KIND_BITS-1:0]    kind;
    logic [TIME_IN_BITS-1:0] time_us;
    logic [BYTE_BITS-1:0]    midi_byte;
    logic [BEAT_BITS-1:0]    sub_division;
    logic [BPM_BITS-1:0]     tempo_bpm;
    logic [BEAT_BITS-1:0]    measure_beats;
    bit                      drain_first;
  } request_t;

  typedef struct {
    logic [PITCH_BITS-1:0]   pitch;
    logic [POS_OUT_BITS-1:0] position;
  } note_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [KIND_BITS-1:0]    kind = '0;
  logic [TIME_IN_BITS-1:0] time_us = '0;
  logic [BYTE_BITS-1:0]    midi_byte = '0;
  logic [BEAT_BITS-1:0]    sub_division = '0;
  logic [BPM_BITS-1:0]     tempo_bpm = '0;
  logic [BEAT_BITS-1:0]    measure_beats = '0;
  logic full;
  logic empty;
  logic [PITCH_BITS-1:0]   note_pitch;
  logic [POS_OUT_BITS-1:0] note_position;

  request_t request_q[$];
  note_t    expected_notes[$];
  request_t cur_req;
  bit       drain_next = 1'b0;

  int unsigned n_accepted = 0;
  int unsigned n_notes = 0;
  int unsigned n_checked = 0;
  int unsigned n_starts = 0;
  int unsigned n_beats = 0;
  int unsigned n_errors = 0;

  // Predictor state, at its reset values
  phase_t                  parse_ph = PH_IDLE;
  bit                      running = 1'b0;
  logic [TIME_IN_BITS-1:0] last_beat_us = '0;
  logic [TIME_IN_BITS-1:0] beat_len_us = '0;
  logic [BEAT_BITS-1:0]    beat_idx = '0;
  logic [BEAT_BITS-1:0]    beats_per_bar = DEFAULT_BEATS;

  midi_drum_note_measure_timestamper dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .time_us       (time_us),
    .midi_byte     (midi_byte),
    .sub_division  (sub_division),
    .tempo_bpm     (tempo_bpm),
    .measure_beats (measure_beats),
    .empty         (empty),
    .pop           (pop),
    .note_pitch    (note_pitch),
    .note_position (note_position)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Position in the bar, full bar = 2^16; only the remainder of whole bars matters.
  function automatic logic [POS_OUT_BITS-1:0] bar_position(input logic [TIME_IN_BITS-1:0] now);
    logic [TIME_IN_BITS-1:0] elapsed;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] rem;
    elapsed = now - last_beat_us;
    sum = 64'(elapsed) + 64'(beat_len_us) * 64'(beat_idx);
    den = 64'(beat_len_us) * 64'(beats_per_bar);
    if (den == 64'd0) return '0;
    rem = sum % den;
    return POS_OUT_BITS'((rem << POS_OUT_BITS) / den);
  endfunction

  function automatic void apply_event(input request_t r);
    note_t n;
    case (r.kind)
      KIND_MIDI: begin
        if (r.midi_byte[7]) begin
          parse_ph = (r.midi_byte == NOTE_ON_CH10) ? PH_NOTE_ON : PH_IDLE;
        end else if (parse_ph == PH_NOTE_ON) begin
          parse_ph = PH_PITCH;
          if (running) begin
            n.pitch = r.midi_byte[PITCH_BITS-1:0];
            n.position = bar_position(r.time_us);
            expected_notes.push_back(n);
            n_notes++;
          end
        end else if (parse_ph == PH_PITCH) begin
          // velocity byte: drop
          parse_ph = PH_IDLE;
        end
      end
      KIND_BEAT: begin
        if (r.sub_division == '0) begin
          beat_len_us = r.time_us - last_beat_us;
          last_beat_us = r.time_us;
          beat_idx = beat_idx + 8'd1;
          if (beat_idx == beats_per_bar) beat_idx = '0;
          n_beats++;
        end
      end
      KIND_START: begin
        beat_len_us = (r.tempo_bpm == '0) ? '0 :
                      TIME_IN_BITS'(US_PER_MINUTE) / TIME_IN_BITS'(r.tempo_bpm);
        last_beat_us = r.time_us - beat_len_us;
        beats_per_bar = (r.measure_beats == '0) ? DEFAULT_BEATS : r.measure_beats;
        beat_idx = beats_per_bar - 8'd1;
        running = 1'b1;
        n_starts++;
      end
      default: begin
        running = 1'b0;
      end
    endcase
  endfunction

  // Sender idles first lightly, then heavily, then never; the receiver the other way.
  function automatic int unsigned idle_percent(input bit sender);
    if (n_accepted < 140) return sender ? 14 : 76;
    if (n_accepted < 280) return sender ? 76 : 14;
    return 0;
  endfunction

  // Fields that the kind does not use get random values.
  task automatic enqueue(input logic [KIND_BITS-1:0] k, input logic [TIME_IN_BITS-1:0] t,
                         input logic [7:0] val, input logic [BPM_BITS-1:0] bpm,
                         input logic [BEAT_BITS-1:0] mb);
    request_t r;
    r.kind = k;
    r.time_us = t;
    r.midi_byte = (k == KIND_MIDI) ? val : BYTE_BITS'($urandom);
    r.sub_division = (k == KIND_BEAT) ? val : BEAT_BITS'($urandom);
    r.tempo_bpm = (k == KIND_START) ? bpm : BPM_BITS'($urandom);
    r.measure_beats = (k == KIND_START) ? mb : BEAT_BITS'($urandom);
    r.drain_first = drain_next;
    drain_next = 1'b0;
    request_q.push_back(r);
  endtask

  task automatic enqueue_note(input logic [TIME_IN_BITS-1:0] t, input logic [6:0] pitch,
                              input logic [6:0] velocity);
    enqueue(KIND_MIDI, t, NOTE_ON_CH10, '0, '0);
    enqueue(KIND_MIDI, t + 32'd1, {1'b0, pitch}, '0, '0);
    enqueue(KIND_MIDI, t + 32'd2, {1'b0, velocity}, '0, '0);
  endtask

  always @(posedge clk) begin : drive
    logic next_push;
    if (rst) begin
      push <= 1'b0;
    end else begin
      next_push = push;
      if (push && !full) begin
        apply_event(cur_req);
        n_accepted++;
        next_push = 1'b0;
      end
      if (!next_push && request_q.size() != 0 &&
          !(request_q[0].drain_first && expected_notes.size() != 0) &&
          $urandom_range(0, 99) >= idle_percent(1'b1)) begin
        cur_req = request_q.pop_front();
        kind <= cur_req.kind;
        time_us <= cur_req.time_us;
        midi_byte <= cur_req.midi_byte;
        sub_division <= cur_req.sub_division;
        tempo_bpm <= cur_req.tempo_bpm;
        measure_beats <= cur_req.measure_beats;
        next_push = 1'b1;
      end
      push <= next_push;
    end
  end

  always @(posedge clk) begin : watch
    note_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_checked++;
        if (expected_notes.size() == 0) begin
          $display("%0t: unexpected note, expected none, actual pitch %0d position %0d",
                   $time, note_pitch, note_position);
          n_errors++;
        end else begin
          want = expected_notes.pop_front();
          if (note_pitch !== want.pitch) begin
            $display("%0t: note_pitch mismatch, expected %0d, actual %0d",
                     $time, want.pitch, note_pitch);
            n_errors++;
          end
          if (note_position !== want.position) begin
            $display("%0t: note_position mismatch, expected %0d, actual %0d",
                     $time, want.position, note_position);
            n_errors++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= idle_percent(1'b0));
    end
  end

  initial begin : stimulus
    logic [TIME_IN_BITS-1:0] t;
    int unsigned sel;
    logic [BPM_BITS-1:0] bpm;
    logic [BEAT_BITS-1:0] mb;

    // Note and stray data byte while stopped; a main beat while stopped
    enqueue_note(32'd1000, 7'h24, 7'h64);
    enqueue(KIND_MIDI, 32'd1100, 8'h10, '0, '0);
    enqueue(KIND_BEAT, 32'd500_000, 8'h00, '0, '0);
    // 120 bpm, default bar of four
    enqueue(KIND_START, 32'd1_000_000, '0, 16'd120, 8'd0);
    enqueue_note(32'd1_250_000, 7'h7F, 7'h00);
    enqueue(KIND_BEAT, 32'd1_500_000, 8'd3, '0, '0);
    enqueue(KIND_BEAT, 32'd1_510_000, 8'd0, '0, '0);
    // a non-note status byte cancels the armed parser
    enqueue(KIND_MIDI, 32'd1_600_000, NOTE_ON_CH10, '0, '0);
    enqueue(KIND_MIDI, 32'd1_600_001, 8'hFF, '0, '0);
    enqueue(KIND_MIDI, 32'd1_600_002, 8'h30, '0, '0);
    // zero tempo gives a zero beat, hence position 0
    enqueue(KIND_START, 32'd2_000_000, '0, 16'd0, 8'd255);
    enqueue_note(32'd2_100_000, 7'h00, 7'h7F);
    // fastest tempo, one beat per bar, time wrapping past zero
    enqueue(KIND_START, 32'hFFFF_FFF0, '0, 16'hFFFF, 8'd1);
    enqueue_note(32'h0000_0100, 7'h55, 7'h2A);
    // note after stop advances the parser only
    enqueue(KIND_STOP, 32'hFFFF_FFFF, '0, '0, '0);
    enqueue(KIND_MIDI, 32'h0000_0200, NOTE_ON_CH10, '0, '0);
    enqueue(KIND_MIDI, 32'h0000_0201, 8'h40, '0, '0);

    // Random part: mostly running bars with beats and complete notes
    drain_next = 1'b1;
    t = 32'd3_000_000;
    while (request_q.size() < 425) begin
      if (request_q.size() >= 220 && request_q.size() < 223) drain_next = 1'b1;
      if ($urandom_range(0, 49) == 0) t = $urandom;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        bpm = ($urandom_range(0, 9) == 0) ? BPM_BITS'($urandom) : BPM_BITS'($urandom_range(30, 300));
        mb = ($urandom_range(0, 7) == 0) ? BEAT_BITS'($urandom) : BEAT_BITS'($urandom_range(0, 12));
        enqueue(KIND_START, t, '0, bpm, mb);
      end else if (sel < 11) begin
        enqueue(KIND_STOP, t, '0, '0, '0);
      end else if (sel < 30) begin
        t = t + $urandom_range(100_000, 700_000);
        enqueue(KIND_BEAT, t, ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'd0,
                '0, '0);
      end else if (sel < 85) begin
        t = t + $urandom_range(0, 200_000);
        enqueue_note(t, 7'($urandom), 7'($urandom));
      end else begin
        // noise and broken sequences: any byte at all
        enqueue(KIND_MIDI, t, 8'($urandom), '0, '0);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || push || expected_notes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d starts, %0d main beats, %0d notes checked.",
             n_accepted, n_starts, n_beats, n_checked);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * MAX_CYCLES);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/mdnt_pkg.sv
src/mdnt_queue.sv
src/mdnt_front.sv
src/mdnt_back.sv
src/midi_drum_note_measure_timestamper.sv
src/mdnt_checker.sv
tb/sv/midi_drum_note_measure_timestamper_tb.sv
